// ===== sv/pctr_pkg.sv =====
// pctr_pkg: shared types, codes and default sizes for the per-cpu trace ring
// no dependencies; every other file of the block but pctr_ram refers to it by scoped names
`timescale 1ns / 1ps

package pctr_pkg;

    localparam int NUM_CPUS_DEF   = 4;
    localparam int RING_DEPTH_DEF = 16;

    localparam int CPU_W  = 2;
    localparam int TYPE_W = 8;
    localparam int ARG_W  = 64;
    localparam int DROP_W = 32;

    localparam logic OP_EMIT = 1'b0;
    localparam logic OP_DUMP = 1'b1;

    typedef struct packed {
        logic              op;
        logic [CPU_W-1:0]  cpu_index;
        logic [TYPE_W-1:0] event_type;
        logic [ARG_W-1:0]  arg_one;
        logic [ARG_W-1:0]  arg_two;
        logic [ARG_W-1:0]  arg_three;
    } t_cmd;

    typedef struct packed {
        logic [CPU_W-1:0]  out_cpu;
        logic [DROP_W-1:0] out_dropped;
        logic [TYPE_W-1:0] out_type;
        logic [ARG_W-1:0]  out_arg_one;
        logic [ARG_W-1:0]  out_arg_two;
        logic [ARG_W-1:0]  out_arg_three;
        logic              last;
    } t_result;

    // one stored event, as held in the ring memory
    typedef struct packed {
        logic [TYPE_W-1:0] event_type;
        logic [ARG_W-1:0]  arg_one;
        logic [ARG_W-1:0]  arg_two;
        logic [ARG_W-1:0]  arg_three;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             en;
        logic [CPU_W-1:0] cpu;
    } t_emit_req;

    // side data that travels with a dump read
    typedef struct packed {
        logic              last;
        logic [CPU_W-1:0]  cpu;
        logic [DROP_W-1:0] dropped;
    } t_dump_meta;

endpackage

// ===== sv/pctr_ram.sv =====
// pctr_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module pctr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/pctr_ptrs.sv =====
// pctr_ptrs: head, tail and drop counter of every ring, updated by emits
// depends on pctr_pkg
`timescale 1ns / 1ps

module pctr_ptrs #(
    parameter int NUM_CPUS   = pctr_pkg::NUM_CPUS_DEF,
    parameter int RING_DEPTH = pctr_pkg::RING_DEPTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  pctr_pkg::t_emit_req                             i_emit,
    output logic [NUM_CPUS-1:0][$clog2(RING_DEPTH)-1:0]     o_head,
    output logic [NUM_CPUS-1:0][$clog2(RING_DEPTH)-1:0]     o_tail,
    output logic [NUM_CPUS-1:0][pctr_pkg::DROP_W-1:0]       o_drop
);

    localparam int PW  = $clog2(RING_DEPTH);
    localparam int CIW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    logic [NUM_CPUS-1:0][PW-1:0]               r_head, n_head;
    logic [NUM_CPUS-1:0][PW-1:0]               r_tail, n_tail;
    logic [NUM_CPUS-1:0][pctr_pkg::DROP_W-1:0] r_drop, n_drop;
    logic [CIW-1:0]                            w_ci;
    logic [PW-1:0]                             w_head_nxt;
    logic [PW-1:0]                             w_tail_nxt;

    assign w_ci       = i_emit.cpu[CIW-1:0];
    assign w_head_nxt = (r_head[w_ci] == PW'(RING_DEPTH - 1)) ? '0 : r_head[w_ci] + 1'b1;
    assign w_tail_nxt = (r_tail[w_ci] == PW'(RING_DEPTH - 1)) ? '0 : r_tail[w_ci] + 1'b1;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_drop = r_drop;
        if (i_emit.en) begin
            n_head[w_ci] = w_head_nxt;
            // ring full: overwrite the oldest event
            if (w_head_nxt == r_tail[w_ci]) begin
                n_tail[w_ci] = w_tail_nxt;
                n_drop[w_ci] = r_drop[w_ci] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_drop <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_drop <= n_drop;
        end
    end

    assign o_head = r_head;
    assign o_tail = r_tail;
    assign o_drop = r_drop;

endmodule

// ===== sv/pctr_walk.sv =====
// pctr_walk: dump sequencer, walks every ring from tail to head and issues ram reads
// depends on pctr_pkg
`timescale 1ns / 1ps

module pctr_walk #(
    parameter int NUM_CPUS   = pctr_pkg::NUM_CPUS_DEF,
    parameter int RING_DEPTH = pctr_pkg::RING_DEPTH_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_dump_go,
    input  logic [NUM_CPUS-1:0][$clog2(RING_DEPTH)-1:0]        i_head,
    input  logic [NUM_CPUS-1:0][$clog2(RING_DEPTH)-1:0]        i_tail,
    input  logic [NUM_CPUS-1:0][pctr_pkg::DROP_W-1:0]          i_drop,
    output logic                                               o_busy,
    output logic                                               o_rd_en,
    output logic [$clog2(NUM_CPUS*RING_DEPTH)-1:0]             o_rd_addr,
    output pctr_pkg::t_dump_meta                               o_meta
);

    localparam int PW  = $clog2(RING_DEPTH);
    localparam int AW  = $clog2(NUM_CPUS * RING_DEPTH);
    localparam int CIW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic                       r_state, n_state;
    logic [pctr_pkg::CPU_W-1:0] r_cpu, n_cpu;
    logic [PW-1:0]              r_cur, n_cur;
    logic [CIW-1:0]             w_ci;
    logic [PW-1:0]              w_cur_nxt;
    logic [PW-1:0]              w_next_tail;
    logic                       w_later;
    logic                       w_last;

    assign w_ci      = r_cpu[CIW-1:0];
    assign w_cur_nxt = (r_cur == PW'(RING_DEPTH - 1)) ? '0 : r_cur + 1'b1;

    // any non-empty ring after the current one, and the tail of the next ring
    always_comb begin
        w_later     = 1'b0;
        w_next_tail = '0;
        for (int c = 0; c < NUM_CPUS; c++) begin
            if (pctr_pkg::CPU_W'(c) > r_cpu && i_head[c] != i_tail[c]) begin
                w_later = 1'b1;
            end
            if (pctr_pkg::CPU_W'(c) == r_cpu + 1'b1) begin
                w_next_tail = i_tail[c];
            end
        end
    end

    assign w_last = (w_cur_nxt == i_head[w_ci]) && !w_later;

    always_comb begin
        n_state   = r_state;
        n_cpu     = r_cpu;
        n_cur     = r_cur;
        o_rd_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_dump_go) begin
                    n_state = S_WALK;
                    n_cpu   = '0;
                    n_cur   = i_tail[0];
                end
            end
            S_WALK: begin
                if (r_cur == i_head[w_ci]) begin
                    // ring exhausted or empty
                    if (r_cpu == pctr_pkg::CPU_W'(NUM_CPUS - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cpu = r_cpu + 1'b1;
                        n_cur = w_next_tail;
                    end
                end else begin
                    o_rd_en = 1'b1;
                    n_cur   = w_cur_nxt;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr      = AW'(AW'(r_cpu) * AW'(RING_DEPTH)) + AW'(r_cur);
    assign o_meta.last    = w_last;
    assign o_meta.cpu     = r_cpu;
    assign o_meta.dropped = i_drop[w_ci];
    assign o_busy         = (r_state == S_WALK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cpu   <= '0;
            r_cur   <= '0;
        end else begin
            r_state <= n_state;
            r_cpu   <= n_cpu;
            r_cur   <= n_cur;
        end
    end

endmodule

// ===== sv/per_cpu_trace_ring.sv =====
// per_cpu_trace_ring: top level, overwriting trace ring per cpu with a dump walk
// depends on pctr_pkg, pctr_ram, pctr_ptrs, pctr_walk
//
//   channel   handshake                  payload
//   command   start in, busy out         i_cmd    (pctr_pkg::t_cmd)
//   result    o_valid strobe, no stall   o_result (pctr_pkg::t_result)
//
// emits can follow back to back; busy stays low
// a dump holds busy while it walks the rings, also when all rings are empty;
// one ram read per event
// each result appears in the cycle after its read, behind the ram's read register
// reset clears pointers and drop counters; the event ram is not cleared
`timescale 1ns / 1ps

module per_cpu_trace_ring #(
    parameter int NUM_CPUS   = pctr_pkg::NUM_CPUS_DEF,
    parameter int RING_DEPTH = pctr_pkg::RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pctr_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output pctr_pkg::t_result o_result
);

    localparam int PW    = $clog2(RING_DEPTH);
    localparam int DEPTH = NUM_CPUS * RING_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CIW   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    logic [NUM_CPUS-1:0][PW-1:0]               w_head;
    logic [NUM_CPUS-1:0][PW-1:0]               w_tail;
    logic [NUM_CPUS-1:0][pctr_pkg::DROP_W-1:0] w_drop;
    logic                                      w_accept;
    logic                                      w_cpu_ok;
    logic                                      w_dump_go;
    pctr_pkg::t_emit_req                       w_emit;
    pctr_pkg::t_entry                          w_wr_entry;
    pctr_pkg::t_entry                          w_rd_entry;
    logic [AW-1:0]                             w_wr_addr;
    logic                                      w_rd_en;
    logic [AW-1:0]                             w_rd_addr;
    pctr_pkg::t_dump_meta                      w_meta;
    logic                                      r_valid;
    pctr_pkg::t_dump_meta                      r_meta;

    assign w_accept  = start && !busy;
    assign w_cpu_ok  = {1'b0, i_cmd.cpu_index} < (pctr_pkg::CPU_W + 1)'(NUM_CPUS);
    assign w_dump_go = w_accept && (i_cmd.op == pctr_pkg::OP_DUMP);

    // emits to a cpu beyond the configured count are dropped silently
    assign w_emit.en  = w_accept && (i_cmd.op == pctr_pkg::OP_EMIT) && w_cpu_ok;
    assign w_emit.cpu = i_cmd.cpu_index;

    assign w_wr_addr = AW'(AW'(i_cmd.cpu_index) * AW'(RING_DEPTH))
                     + AW'(w_head[i_cmd.cpu_index[CIW-1:0]]);

    assign w_wr_entry.event_type = i_cmd.event_type;
    assign w_wr_entry.arg_one    = i_cmd.arg_one;
    assign w_wr_entry.arg_two    = i_cmd.arg_two;
    assign w_wr_entry.arg_three  = i_cmd.arg_three;

    pctr_ptrs #(
        .NUM_CPUS   (NUM_CPUS),
        .RING_DEPTH (RING_DEPTH)
    ) u_ptrs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .o_head  (w_head),
        .o_tail  (w_tail),
        .o_drop  (w_drop)
    );

    pctr_walk #(
        .NUM_CPUS   (NUM_CPUS),
        .RING_DEPTH (RING_DEPTH)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dump_go (w_dump_go),
        .i_head    (w_head),
        .i_tail    (w_tail),
        .i_drop    (w_drop),
        .o_busy    (busy),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .o_meta    (w_meta)
    );

    // writes only happen while idle, so reads and writes never meet
    pctr_ram #(
        .WIDTH (pctr_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_emit.en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_meta <= w_meta;
        end
    end

    assign o_valid                = r_valid;
    assign o_result.out_cpu       = r_meta.cpu;
    assign o_result.out_dropped   = r_meta.dropped;
    assign o_result.out_type      = w_rd_entry.event_type;
    assign o_result.out_arg_one   = w_rd_entry.arg_one;
    assign o_result.out_arg_two   = w_rd_entry.arg_two;
    assign o_result.out_arg_three = w_rd_entry.arg_three;
    assign o_result.last          = r_meta.last;

endmodule

// ===== sv/pctr_checker.sv =====
// pctr_checker: port-level assertions for per_cpu_trace_ring, bound to the top
// depends on pctr_pkg and per_cpu_trace_ring
`timescale 1ns / 1ps

module pctr_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input pctr_pkg::t_cmd    i_cmd,
    input logic              o_valid,
    input pctr_pkg::t_result o_result
);

    // a result beat only follows a cycle of dump walking
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without a dump in progress");

    // nothing is read in the cycle a command is taken
    a_no_beat_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result beat right after a command beat");

    a_dump_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.op == pctr_pkg::OP_DUMP) |=> busy)
        else $error("dump did not raise busy");

    a_emit_keeps_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.op == pctr_pkg::OP_EMIT) |=> !busy)
        else $error("emit raised busy");

    // the last beat of a dump coincides with busy dropping, no earlier
    a_last_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (busy != o_result.last))
        else $error("last flag and busy disagree");

endmodule

bind per_cpu_trace_ring pctr_checker u_pctr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .o_result (o_result)
);
